>>> src/bhca_pkg.sv
package bhca_pkg;

  // Command codes carried by the input beat.
  localparam logic [1:0] CMD_SIGNAL = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_INDIV = 2'd0;
  localparam logic [1:0] CFG_MIN_AGGR  = 2'd1;
  localparam logic [1:0] CFG_MIN_TICKS = 2'd2;

  // Fixed encodings and limits.
  localparam logic [15:0]       EMPTY_ID  = 16'hffff;
  localparam logic [7:0]        PCT_LIMIT = 8'd100;
  localparam logic [4:0]        LIST_CAP  = 5'd16;
  localparam logic signed [7:0] TIMER_MIN = 8'sh80;
  localparam logic [7:0]        TICKS_SAT = 8'hff;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [15:0]       id;
    logic [6:0]        pct;
    logic signed [7:0] tmr;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // latch a new item and clear the walk state
    logic walk;   // walk the table one entry per cycle unless an output stall holds it
    logic fin;    // apply the end-of-item update and load the final result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;  // the walk is not held and no read is left to issue
    logic out_free;   // the output register can take a result this cycle
  } ctl_stat_t;

endpackage

>>> src/boiler_heat_call_aggregator_top.sv
// Channel | Handshake              | Payload
// in_     | in_valid / in_stall    | cmd, valve_id, percent_open, max_entries, only_calling
// out_    | out_valid / out_stall  | accepted, call_for_heat, entry_*, listed_count, last
// cfg_    | cfg_valid / cfg_ready  | cfg_addr (register index), cfg_wdata
//
// One item is handled at a time; a signal or tick is paced by the table walk that reads
// one entry per cycle, and the unused command skips the walk and goes to the final beat.
// A status read walks until its cap is met or the table ends, and is held while the
// output stalls.
// Reset is synchronous and active low; it empties the table by clearing the fill count.
// Output stalls hold the walk on the entry being listed; the input stalls until the
// final beat of the item is loaded into the output register.
module boiler_heat_call_aggregator_top
  import bhca_pkg::*;
#(
  parameter int MAX_VALVES        = 16,
  parameter int SIGNAL_LIFE_TICKS = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [15:0]       in_valve_id,
  input  logic [7:0]        in_percent_open,
  input  logic [4:0]        in_max_entries,
  input  logic              in_only_calling,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic              out_call_for_heat,
  output logic              out_entry_valid,
  output logic [15:0]       out_entry_id,
  output logic [6:0]        out_entry_pct,
  output logic signed [7:0] out_entry_ticks,
  output logic [4:0]        out_listed_count,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_addr,
  input  logic [7:0]        cfg_wdata
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Registers accept a write on every cycle.
  assign cfg_ready = 1'b1;

  bhca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bhca_dp #(
    .MAX_VALVES        (MAX_VALVES),
    .SIGNAL_LIFE_TICKS (SIGNAL_LIFE_TICKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (in_cmd),
    .in_valve_id       (in_valve_id),
    .in_percent_open   (in_percent_open),
    .in_max_entries    (in_max_entries),
    .in_only_calling   (in_only_calling),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_call_for_heat (out_call_for_heat),
    .out_entry_valid   (out_entry_valid),
    .out_entry_id      (out_entry_id),
    .out_entry_pct     (out_entry_pct),
    .out_entry_ticks   (out_entry_ticks),
    .out_listed_count  (out_listed_count),
    .out_last          (out_last)
  );

endmodule

>>> src/bhca_ctrl.sv
module bhca_ctrl
  import bhca_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_cmd,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // The controller takes a new beat only between items.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_cmd == CMD_NONE) ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath.
  assign cmd.start = accept;
  assign cmd.walk  = (state_r == ST_WALK);
  assign cmd.fin   = (state_r == ST_FIN) && stat.out_free;

  // A final result always returns the controller to idle.
  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after the final result");

  // A new item never starts while a walk is running.
  a_no_start_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> !cmd.start)
    else $error("item accepted during a table walk");

  // Exactly one state bit is set at all times.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");

endmodule

>>> src/bhca_dp.sv
module bhca_dp
  import bhca_pkg::*;
#(
  parameter int MAX_VALVES        = 16,
  parameter int SIGNAL_LIFE_TICKS = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output ctl_stat_t         stat,
  input  logic [1:0]        in_cmd,
  input  logic [15:0]       in_valve_id,
  input  logic [7:0]        in_percent_open,
  input  logic [4:0]        in_max_entries,
  input  logic              in_only_calling,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_addr,
  input  logic [7:0]        cfg_wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic              out_call_for_heat,
  output logic              out_entry_valid,
  output logic [15:0]       out_entry_id,
  output logic [6:0]        out_entry_pct,
  output logic signed [7:0] out_entry_ticks,
  output logic [4:0]        out_listed_count,
  output logic              out_last
);

  localparam int AW = (MAX_VALVES > 1) ? $clog2(MAX_VALVES) : 1;
  localparam int CW = $clog2(MAX_VALVES + 1);
  localparam logic [CW-1:0]       MAX_N = CW'(MAX_VALVES);
  localparam logic signed [7:0]   LIFE  = 8'(SIGNAL_LIFE_TICKS);

  // Configuration registers.
  logic [6:0] min_indiv_r, min_aggr_r;
  logic [7:0] min_ticks_r;

  // Item registers.
  logic [1:0]  cmd_r;
  logic [15:0] id_r;
  logic [7:0]  pct_r;
  logic [4:0]  maxe_r;
  logic        only_r;

  // Table state.
  entry_t        mem [MAX_VALVES];
  logic [CW-1:0] filled_r;
  logic          boiler_r, boiler_nxt;
  logic [7:0]    tsc_r, tsc_nxt, tsc_inc;

  // Walk state.
  logic [CW-1:0] rd_idx_r;
  logic [AW-1:0] ent_idx_r;
  entry_t        ent_r;
  logic          ent_v_r;
  logic          found_r, found_nxt;
  logic [4:0]    count_r, count_nxt;
  logic          calling_r, calling_nxt;
  logic [7:0]    sum_r, sum_nxt;

  // Output register.
  logic              out_valid_r;
  logic              acc_r, cfh_r, ev_r, last_r;
  logic [15:0]       oid_r;
  logic [6:0]        opct_r;
  logic signed [7:0] otmr_r;
  logic [4:0]        ocnt_r;

  logic [6:0]        indiv, aggr;
  logic              is_sig, is_tick, is_stat, sig_ok;
  logic              qual, emit, hold, proc, match, stop, issue;
  logic              tk_act, t_live, room, want, out_free;
  logic signed [7:0] t_dec;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  // Effective thresholds, clamped into their legal ranges.
  always_comb begin
    indiv = min_indiv_r;
    if (indiv == 7'd0) indiv = 7'd1;
    if (indiv > PCT_LIMIT[6:0]) indiv = PCT_LIMIT[6:0];
    aggr = min_aggr_r;
    if (aggr < indiv) aggr = indiv;
    if (aggr > PCT_LIMIT[6:0]) aggr = PCT_LIMIT[6:0];
  end

  // Configuration writes; the port is always ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_indiv_r <= 7'd50;
      min_aggr_r  <= 7'd50;
      min_ticks_r <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_MIN_INDIV: min_indiv_r <= cfg_wdata[6:0];
        CFG_MIN_AGGR:  min_aggr_r  <= cfg_wdata[6:0];
        CFG_MIN_TICKS: min_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the accepted input beat.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r  <= in_cmd;
      id_r   <= in_valve_id;
      pct_r  <= in_percent_open;
      maxe_r <= (in_max_entries > LIST_CAP) ? LIST_CAP : in_max_entries;
      only_r <= in_only_calling;
    end
  end

  assign is_sig  = (cmd_r == CMD_SIGNAL);
  assign is_tick = (cmd_r == CMD_TICK);
  assign is_stat = (cmd_r == CMD_STATUS);
  assign sig_ok  = (id_r != EMPTY_ID) && (pct_r <= PCT_LIMIT);
  assign room    = (filled_r < MAX_N);

  assign out_free = !out_valid_r || !out_stall;

  // Per-entry evaluation of the entry held in the registered read port.
  assign qual  = !only_r || (!ent_r.tmr[7] && (ent_r.pct >= indiv));
  assign emit  = cmd.walk && ent_v_r && is_stat && qual;
  assign hold  = emit && !out_free;
  assign proc  = cmd.walk && ent_v_r && !hold;
  assign match = proc && is_sig && sig_ok && !found_r && (ent_r.id == id_r);

  assign tk_act = proc && is_tick && (ent_r.tmr != TIMER_MIN);
  assign t_dec  = ent_r.tmr - 8'sd1;
  assign t_live = tk_act && !t_dec[7];

  always_comb begin
    found_nxt   = found_r || match;
    count_nxt   = (proc && emit) ? (count_r + 5'd1) : count_r;
    calling_nxt = calling_r || (t_live && (ent_r.pct >= indiv));
    sum_nxt     = (t_live && (sum_r < {1'b0, aggr})) ? (sum_r + {1'b0, ent_r.pct}) : sum_r;
    case (cmd_r)
      CMD_SIGNAL: stop = found_nxt;
      CMD_STATUS: stop = (count_nxt >= maxe_r);
      default:    stop = 1'b0;
    endcase
  end

  assign issue          = cmd.walk && !hold && (rd_idx_r < filled_r) && !stop;
  assign stat.walk_done = cmd.walk && !hold && !issue;
  assign stat.out_free  = out_free;

  // Walk registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
    end else if (cmd.start) begin
      ent_v_r <= 1'b0;
    end else if (cmd.walk && !hold) begin
      ent_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_idx_r  <= '0;
      found_r   <= 1'b0;
      count_r   <= 5'd0;
      calling_r <= 1'b0;
      sum_r     <= 8'd0;
    end else if (cmd.walk && !hold) begin
      if (issue) rd_idx_r <= rd_idx_r + CW'(1);
      found_r   <= found_nxt;
      count_r   <= count_nxt;
      calling_r <= calling_nxt;
      sum_r     <= sum_nxt;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ent_idx_r;
    wr_data = '{id: id_r, pct: pct_r[6:0], tmr: LIFE};
    if (match) begin
      wr_en = 1'b1;
    end else if (tk_act) begin
      wr_en   = 1'b1;
      wr_data = '{id: ent_r.id, pct: ent_r.pct, tmr: t_dec};
    end else if (cmd.fin && is_sig && sig_ok && !found_r && room) begin
      wr_en   = 1'b1;
      wr_addr = filled_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ent_r     <= mem[rd_idx_r[AW-1:0]];
      ent_idx_r <= rd_idx_r[AW-1:0];
    end
  end

  // Boiler decision at the end of a tick.
  assign want    = calling_r && (sum_r >= {1'b0, aggr});
  assign tsc_inc = (tsc_r == TICKS_SAT) ? TICKS_SAT : (tsc_r + 8'd1);

  always_comb begin
    boiler_nxt = boiler_r;
    tsc_nxt    = tsc_inc;
    if ((want != boiler_r) && (tsc_inc >= min_ticks_r)) begin
      boiler_nxt = want;
      tsc_nxt    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      boiler_r <= 1'b0;
      tsc_r    <= 8'd0;
    end else if (cmd.fin) begin
      if (is_sig && sig_ok && !found_r && room) filled_r <= filled_r + CW'(1);
      if (is_tick) begin
        boiler_r <= boiler_nxt;
        tsc_r    <= tsc_nxt;
      end
    end
  end

  // Output register: a listed entry during the walk, the final beat at the end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((proc && emit) || cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      acc_r  <= 1'b0;
      cfh_r  <= boiler_r;
      ev_r   <= 1'b1;
      oid_r  <= ent_r.id;
      opct_r <= ent_r.pct;
      otmr_r <= ent_r.tmr;
      ocnt_r <= 5'd0;
      last_r <= 1'b0;
    end else if (cmd.fin) begin
      acc_r  <= is_sig && sig_ok && (found_r || room);
      cfh_r  <= is_tick ? boiler_nxt : boiler_r;
      ev_r   <= 1'b0;
      oid_r  <= 16'd0;
      opct_r <= 7'd0;
      otmr_r <= 8'sd0;
      ocnt_r <= is_stat ? count_r : 5'd0;
      last_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_call_for_heat = cfh_r;
  assign out_entry_valid   = ev_r;
  assign out_entry_id      = oid_r;
  assign out_entry_pct     = opct_r;
  assign out_entry_ticks   = otmr_r;
  assign out_listed_count  = ocnt_r;
  assign out_last          = last_r;

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= MAX_N)
    else $error("fill count exceeds table size");

  // An entry is in flight only while the table is being walked.
  a_ent_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ent_v_r |-> cmd.walk)
    else $error("entry read outside a table walk");

  // A status read never lists more than it was asked for.
  a_list_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk && is_stat) |-> (count_r <= maxe_r))
    else $error("status read listed too many entries");

endmodule
